[design/fixed_point_q24_8_alu_assert.svh]
// ----------------------------------------------------------------------------
// Fixed-point ALU assertion macros
// Concurrent assertion wrappers that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH

`ifndef SYNTHESIS

// Implication checked at every rising clock edge outside reset.
`define FPA_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fixed-point ALU assertion failed");

// Free-form property checked at every rising clock edge outside reset.
`define FPA_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fixed-point ALU assertion failed");

`else

`define FPA_ASSERT_IMP(name, clk, rstn, ante, cons)
`define FPA_ASSERT(name, clk, rstn, prop)

`endif

`endif

[design/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Shared operation codes, payload structs and default configuration.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int DATA_WIDTH_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 8;
  localparam int PORT_W            = 32;
  localparam int OP_W              = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_CMP = 4'd4,
    OP_MIN = 4'd5,
    OP_MAX = 4'd6,
    OP_INC = 4'd7,
    OP_DEC = 4'd8,
    OP_I2F = 4'd9,
    OP_F2I = 4'd10
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [PORT_W-1:0] operand_a;
    logic signed [PORT_W-1:0] operand_b;
  } cmd_t;

  typedef struct packed {
    logic signed [PORT_W-1:0] result_value;
    logic                     is_greater;
    logic                     is_less;
    logic                     is_equal;
    logic                     overflowed;
    logic                     divided_by_zero;
  } res_t;

  // Status that the multiply and divide units hand back with their value.
  typedef struct packed {
    logic ovf;
    logic dbz;
  } flags_t;

endpackage

[design/fpa_mul.sv]
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Pipelined signed multiply, round half away from zero, saturate.
// ----------------------------------------------------------------------------
module fpa_mul #(
  parameter int DATA_WIDTH    = fpa_pkg::DATA_WIDTH_DEF,
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF,
  parameter int LATENCY       = 4
) (
  input  logic                         clk_i,
  input  logic signed [DATA_WIDTH-1:0] a_i,
  input  logic signed [DATA_WIDTH-1:0] b_i,
  output logic signed [DATA_WIDTH-1:0] prod_o,
  output fpa_pkg::flags_t              flags_o
);

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRACTION_BITS;
  localparam int PW2 = 2 * DW;
  localparam int TAIL = LATENCY - 4;
  localparam logic [PW2-1:0] HALF = PW2'(1) << (FB - 1);
  localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [PW2-1:0] prod_q;
  logic                  neg2_q;
  logic [PW2-1:0]        mag_q;
  logic                  neg3_q;
  logic [PW2-1:0]        rnd_q;
  logic [DW-1:0]         val_d;
  logic                  ovf_d;
  logic [DW-1:0]         val_q;
  logic                  ovf_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    neg2_q <= prod_q[PW2-1];
    mag_q  <= prod_q[PW2-1] ? (~prod_q + PW2'(1)) : prod_q;
    neg3_q <= neg2_q;
    rnd_q  <= (mag_q + HALF) >> FB;
    val_q  <= val_d;
    ovf_q  <= ovf_d;
  end

  // A negative result may reach one step further than a positive one.
  always_comb begin
    if (neg3_q) begin
      ovf_d = (|rnd_q[PW2-1:DW]) | (rnd_q[DW-1] & (|rnd_q[DW-2:0]));
      val_d = ovf_d ? SAT_MIN : (~rnd_q[DW-1:0] + DW'(1));
    end else begin
      ovf_d = |rnd_q[PW2-1:DW-1];
      val_d = ovf_d ? SAT_MAX : rnd_q[DW-1:0];
    end
  end

  generate
    if (TAIL > 0) begin : g_tail
      logic [DW-1:0] tval_q [TAIL];
      logic          tovf_q [TAIL];

      always_ff @(posedge clk_i) begin
        tval_q[0] <= val_q;
        tovf_q[0] <= ovf_q;
        for (int i = 1; i < TAIL; i++) begin
          tval_q[i] <= tval_q[i-1];
          tovf_q[i] <= tovf_q[i-1];
        end
      end

      assign prod_o      = signed'(tval_q[TAIL-1]);
      assign flags_o.ovf = tovf_q[TAIL-1];
    end else begin : g_no_tail
      assign prod_o      = signed'(val_q);
      assign flags_o.ovf = ovf_q;
    end
  endgenerate

  assign flags_o.dbz = 1'b0;

endmodule

[design/fpa_div.sv]
// ----------------------------------------------------------------------------
// Fixed-point divider
// Pipelined restoring divider, one quotient bit per stage, with rounding.
// ----------------------------------------------------------------------------
module fpa_div #(
  parameter int DATA_WIDTH    = fpa_pkg::DATA_WIDTH_DEF,
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic signed [DATA_WIDTH-1:0] a_i,
  input  logic signed [DATA_WIDTH-1:0] b_i,
  output logic signed [DATA_WIDTH-1:0] quot_o,
  output fpa_pkg::flags_t              flags_o
);

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRACTION_BITS;
  localparam int NW = DW + FB;
  localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] low;
    logic [DW-1:0] quo;
    logic [DW-1:0] den;
    logic          neg;
    logic          dbz;
    logic          huge;
  } dst_t;

  logic [DW-1:0] amag_w;
  logic [DW-1:0] bmag_w;
  logic [NW-1:0] num_w;
  dst_t          st_d [DW+1];
  dst_t          st_q [DW+1];
  logic [DW:0]   r2_w [DW];
  logic          ge_w [DW];
  logic          rnd_w;
  logic [DW:0]   qr_q;
  logic          neg_q;
  logic          dbz_q;
  logic          huge_q;
  logic [DW-1:0] val_d;
  logic          ovf_d;
  logic [DW-1:0] val_q;
  logic          ovf_q;
  logic          dbzo_q;

  // The dividend is |a| scaled by the fraction bits. Its top FB bits seed
  // the remainder; if they already reach the divisor the quotient needs more
  // than DW bits and the result saturates.
  always_comb begin
    amag_w = a_i[DW-1] ? (~a_i + DW'(1)) : a_i;
    bmag_w = b_i[DW-1] ? (~b_i + DW'(1)) : b_i;
    num_w  = {amag_w, {FB{1'b0}}};

    st_d[0].rem  = DW'(num_w[NW-1:DW]);
    st_d[0].low  = num_w[DW-1:0];
    st_d[0].quo  = '0;
    st_d[0].den  = bmag_w;
    st_d[0].neg  = a_i[DW-1] ^ b_i[DW-1];
    st_d[0].dbz  = (b_i == '0);
    st_d[0].huge = (DW'(num_w[NW-1:DW]) >= bmag_w);

    for (int k = 0; k < DW; k++) begin
      r2_w[k] = {st_q[k].rem, st_q[k].low[DW-1]};
      ge_w[k] = (r2_w[k] >= {1'b0, st_q[k].den});
      st_d[k+1]      = st_q[k];
      st_d[k+1].rem  = ge_w[k] ? DW'(r2_w[k] - {1'b0, st_q[k].den}) : DW'(r2_w[k]);
      st_d[k+1].low  = {st_q[k].low[DW-2:0], 1'b0};
      st_d[k+1].quo  = {st_q[k].quo[DW-2:0], ge_w[k]};
    end

    // Round half away from zero: add one when twice the remainder reaches
    // the divisor.
    rnd_w = ({st_q[DW].rem, 1'b0} >= {1'b0, st_q[DW].den});
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= DW; k++) begin
      st_q[k] <= st_d[k];
    end
    qr_q   <= {1'b0, st_q[DW].quo} + (DW+1)'(rnd_w);
    neg_q  <= st_q[DW].neg;
    dbz_q  <= st_q[DW].dbz;
    huge_q <= st_q[DW].huge;
    val_q  <= val_d;
    ovf_q  <= ovf_d;
    dbzo_q <= dbz_q;
  end

  always_comb begin
    if (dbz_q) begin
      ovf_d = 1'b0;
      val_d = '0;
    end else if (neg_q) begin
      ovf_d = huge_q | qr_q[DW] | (qr_q[DW-1] & (|qr_q[DW-2:0]));
      val_d = ovf_d ? SAT_MIN : (~qr_q[DW-1:0] + DW'(1));
    end else begin
      ovf_d = huge_q | qr_q[DW] | qr_q[DW-1];
      val_d = ovf_d ? SAT_MAX : qr_q[DW-1:0];
    end
  end

  assign quot_o      = signed'(val_q);
  assign flags_o.ovf = ovf_q;
  assign flags_o.dbz = dbzo_q;

endmodule

[design/fixed_point_q24_8_alu.sv]
// ----------------------------------------------------------------------------
// Fixed-point Q24.8 ALU
// Pipelined signed fixed-point arithmetic unit with saturation and flags.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken at a rising clock edge with start_i high and busy_o
//   low. busy_o stays low, so a new command can be issued in every cycle.
//   Each command yields exactly one result on result_o, marked by done_o for
//   a single cycle; the receiver must take it in that cycle.
//   The result passes through the input stage, the aligned operation pipeline
//   and the output register, and is taken at the edge that ends its done_o
//   cycle. Throughput is one transaction per cycle for every operation.
//   The latency is set by the divider, which resolves one quotient bit per
//   pipeline stage; all other operations are delayed to match, so results
//   leave in the order the commands came in.
//   Operands are used as DATA_WIDTH-bit two's complement values; the result
//   value is sign extended to the 32-bit port.
//   Reset clears all valid bits, so no done_o strobe follows reset until a
//   new command is accepted. There is no back pressure on the result side.
// ----------------------------------------------------------------------------
`include "fixed_point_q24_8_alu_assert.svh"

module fixed_point_q24_8_alu #(
  parameter int DATA_WIDTH    = fpa_pkg::DATA_WIDTH_DEF,
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  fpa_pkg::cmd_t cmd_i,
  output logic          busy_o,
  output logic          done_o,
  output fpa_pkg::res_t result_o
);

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRACTION_BITS;
  localparam int PW = fpa_pkg::PORT_W;
  localparam int OW = fpa_pkg::OP_W;
  localparam int DIV_LAT = DW + 3;
  localparam int TOTAL_LAT = DIV_LAT + 2;
  localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic [OW-1:0] op;
    logic [DW-1:0] val;
    logic          ovf;
    logic          gt;
    logic          lt;
    logic          eq;
  } side_t;

  // Returns {overflow, saturated value} for a sum that is one bit wider.
  function automatic logic [DW:0] sat_sum(input logic [DW:0] x);
    logic          ovf;
    logic [DW-1:0] val;
    ovf = x[DW] ^ x[DW-1];
    val = ovf ? (x[DW] ? SAT_MIN : SAT_MAX) : x[DW-1:0];
    return {ovf, val};
  endfunction

  logic                 vld_s0_q;
  logic [OW-1:0]        op_s0_q;
  logic signed [DW-1:0] a_s0_q;
  logic signed [DW-1:0] b_s0_q;

  logic [DW:0]          sum_w;
  logic [DW:0]          dif_w;
  logic [DW:0]          inc_w;
  logic [DW:0]          dec_w;
  logic [DW+FB-1:0]     shl_w;
  logic                 shl_ovf_w;
  side_t                side_d;
  side_t                side_q [DIV_LAT];
  logic [DIV_LAT-1:0]   vld_q;

  logic signed [DW-1:0] mul_val;
  fpa_pkg::flags_t      mul_flags;
  logic signed [DW-1:0] div_val;
  fpa_pkg::flags_t      div_flags;

  side_t                side_w;
  logic [DW-1:0]        out_val_w;
  fpa_pkg::res_t        res_d;
  fpa_pkg::res_t        res_q;
  logic                 done_q;

  assign busy_o = 1'b0;

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s0_q <= 1'b0;
    end else begin
      vld_s0_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    op_s0_q <= cmd_i.operation;
    a_s0_q  <= signed'(cmd_i.operand_a[DW-1:0]);
    b_s0_q  <= signed'(cmd_i.operand_b[DW-1:0]);
  end

  // Combinational operations and the comparison flags.
  always_comb begin
    sum_w     = {a_s0_q[DW-1], a_s0_q} + {b_s0_q[DW-1], b_s0_q};
    dif_w     = {a_s0_q[DW-1], a_s0_q} - {b_s0_q[DW-1], b_s0_q};
    inc_w     = {a_s0_q[DW-1], a_s0_q} + (DW+1)'(1);
    dec_w     = {a_s0_q[DW-1], a_s0_q} - (DW+1)'(1);
    shl_w     = {a_s0_q, {FB{1'b0}}};
    // The shift fits only if every bit above the new sign bit copies it.
    shl_ovf_w = (shl_w[DW+FB-1:DW-1] != '0) && (shl_w[DW+FB-1:DW-1] != '1);

    side_d.op  = op_s0_q;
    side_d.gt  = (a_s0_q > b_s0_q);
    side_d.lt  = (a_s0_q < b_s0_q);
    side_d.eq  = (a_s0_q == b_s0_q);
    side_d.ovf = 1'b0;
    side_d.val = '0;

    case (op_s0_q)
      fpa_pkg::OP_ADD: begin
        {side_d.ovf, side_d.val} = sat_sum(sum_w);
      end
      fpa_pkg::OP_SUB: begin
        {side_d.ovf, side_d.val} = sat_sum(dif_w);
      end
      fpa_pkg::OP_INC: begin
        {side_d.ovf, side_d.val} = sat_sum(inc_w);
      end
      fpa_pkg::OP_DEC: begin
        {side_d.ovf, side_d.val} = sat_sum(dec_w);
      end
      fpa_pkg::OP_MIN: begin
        side_d.val = side_d.lt ? a_s0_q : b_s0_q;
      end
      fpa_pkg::OP_MAX: begin
        side_d.val = side_d.gt ? a_s0_q : b_s0_q;
      end
      fpa_pkg::OP_I2F: begin
        side_d.ovf = shl_ovf_w;
        side_d.val = shl_ovf_w ? (a_s0_q[DW-1] ? SAT_MIN : SAT_MAX) : shl_w[DW-1:0];
      end
      fpa_pkg::OP_F2I: begin
        side_d.val = a_s0_q >>> FB;
      end
      default: begin
        side_d.val = '0;
      end
    endcase
  end

  // Delay line that keeps the simple results aligned with the divider.
  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < DIV_LAT; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_LAT-2:0], vld_s0_q};
    end
  end

  fpa_mul #(
    .DATA_WIDTH   (DW),
    .FRACTION_BITS(FB),
    .LATENCY      (DIV_LAT)
  ) u_mul (
    .clk_i  (clk_i),
    .a_i    (a_s0_q),
    .b_i    (b_s0_q),
    .prod_o (mul_val),
    .flags_o(mul_flags)
  );

  fpa_div #(
    .DATA_WIDTH   (DW),
    .FRACTION_BITS(FB)
  ) u_div (
    .clk_i  (clk_i),
    .a_i    (a_s0_q),
    .b_i    (b_s0_q),
    .quot_o (div_val),
    .flags_o(div_flags)
  );

  // Result select and output register.
  always_comb begin
    side_w = side_q[DIV_LAT-1];

    res_d.is_greater = side_w.gt;
    res_d.is_less    = side_w.lt;
    res_d.is_equal   = side_w.eq;

    case (side_w.op)
      fpa_pkg::OP_MUL: begin
        out_val_w             = mul_val;
        res_d.overflowed      = mul_flags.ovf;
        res_d.divided_by_zero = mul_flags.dbz;
      end
      fpa_pkg::OP_DIV: begin
        out_val_w             = div_val;
        res_d.overflowed      = div_flags.ovf;
        res_d.divided_by_zero = div_flags.dbz;
      end
      default: begin
        out_val_w             = side_w.val;
        res_d.overflowed      = side_w.ovf;
        res_d.divided_by_zero = 1'b0;
      end
    endcase

    res_d.result_value = PW'(signed'(out_val_w));
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[DIV_LAT-1];
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // A divide by zero never also reports an overflow.
  `FPA_ASSERT_IMP(a_dbz_no_ovf, clk_i, rst_ni, done_o,
                  !(result_o.divided_by_zero && result_o.overflowed))

  // A divide by zero returns zero.
  `FPA_ASSERT_IMP(a_dbz_zero, clk_i, rst_ni, done_o && result_o.divided_by_zero,
                  result_o.result_value == '0)

  // Exactly one comparison flag is set in every result.
  `FPA_ASSERT_IMP(a_cmp_onehot, clk_i, rst_ni, done_o,
                  (2'(result_o.is_greater) + 2'(result_o.is_less)
                   + 2'(result_o.is_equal)) == 2'd1)

  // Every result strobe belongs to a command accepted a fixed time earlier.
  `FPA_ASSERT(a_fixed_latency, clk_i, rst_ni,
              done_o |-> $past(start_i && !busy_o, TOTAL_LAT))

endmodule
